// File: rtl/nssr_pkg.sv
// ---------------------------------------------------------------------------
// nssr_pkg
// Shared widths, latencies and register indices for the nearest-neighbour
// rectangle scaler.
// ---------------------------------------------------------------------------
package nssr_pkg;

	// Width of a dimension register and of a mapped target position.
	localparam int DIM_W = 13;
	// Width of a source boundary (position plus size).
	localparam int POS_W = 14;
	// Width of the dividend held through the divider stages.
	localparam int REM_W = 29;
	// Latency of one boundary mapper, input to registered output.
	localparam int BM_LAT = 16;

	// Configuration register indices.
	localparam logic [2:0] REG_SRC_W   = 3'd0;
	localparam logic [2:0] REG_SRC_H   = 3'd1;
	localparam logic [2:0] REG_FRM_W   = 3'd2;
	localparam logic [2:0] REG_FRM_H   = 3'd3;
	localparam logic [2:0] REG_HI_BYTE = 3'd4;

endpackage

// File: rtl/nearest_scale_rect_to_rgb565.sv
// ---------------------------------------------------------------------------
// nearest_scale_rect_to_rgb565
// Maps solid-colour source rectangles onto a target frame by centre-sampled
// nearest-neighbour scaling and packs the colour as RGB565.
// ---------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------
//  input     | start, busy         | rect_left/top/cols/rows, red/green/blue
//  config    | cfg_valid, cfg_ready| cfg_index, cfg_data
//  result    | done (one cycle)    | spans, bytes, start_offset, empty_span
//
// One rectangle is taken in every cycle.
// The latency is set by the thirteen-stage restoring divider in each of the
// four boundary mappers, plus input, arithmetic, select and offset stages.
// busy is never raised and results cannot be held off, so nothing stalls.
// Reset clears the valid pipeline and sets the configuration registers to their defaults.
// ---------------------------------------------------------------------------
module nearest_scale_rect_to_rgb565
	import nssr_pkg::*;
#(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [11:0]      rect_left,
	input  logic [11:0]      rect_top,
	input  logic [12:0]      rect_cols,
	input  logic [12:0]      rect_rows,
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [12:0]      cfg_data,
	output logic             done,
	output logic [12:0]      col_begin,
	output logic [12:0]      col_end,
	output logic [12:0]      row_begin,
	output logic [12:0]      row_end,
	output logic [7:0]       first_byte,
	output logic [7:0]       second_byte,
	output logic [24:0]      start_offset,
	output logic             empty_span
);

	localparam logic [DIM_W-1:0] DIM_MAX =
		(MAX_DIMENSION > 8191) ? 13'h1FFF : DIM_W'(MAX_DIMENSION);
	localparam int LAST = BM_LAT + 1;

	logic [DIM_W-1:0] src_w_q, src_h_q, frm_w_q, frm_h_q;
	logic             hi_first_q;
	logic             accept;
	logic [POS_W-1:0] cb_s1, ce_s1, rb_s1, re_s1;
	logic [LAST:1]    vld_s;
	logic [15:0]      col_s [1:LAST];
	logic [DIM_W-1:0] cb_t, ce_t, rb_t, re_t;
	logic             empty;
	logic [23:0]      pix;

	// Size register value with zero read as one and large values clamped.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_MAX) begin
			r = DIM_MAX;
		end
		return r;
	endfunction

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration registers; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q    <= DIM_W'(1);
			src_h_q    <= DIM_W'(1);
			frm_w_q    <= DIM_W'(1);
			frm_h_q    <= DIM_W'(1);
			hi_first_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SRC_W:   src_w_q    <= clamp_dim(cfg_data);
				REG_SRC_H:   src_h_q    <= clamp_dim(cfg_data);
				REG_FRM_W:   frm_w_q    <= clamp_dim(cfg_data);
				REG_FRM_H:   frm_h_q    <= clamp_dim(cfg_data);
				REG_HI_BYTE: hi_first_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Valid bits travel alongside the data pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done  <= 1'b0;
		end else begin
			vld_s <= {vld_s[LAST-1:1], accept};
			done  <= vld_s[LAST];
		end
	end

	// Input stage: boundaries and packed colour.
	always_ff @(posedge clk) begin
		cb_s1    <= {2'b00, rect_left};
		ce_s1    <= {2'b00, rect_left} + {1'b0, rect_cols};
		rb_s1    <= {2'b00, rect_top};
		re_s1    <= {2'b00, rect_top} + {1'b0, rect_rows};
		col_s[1] <= {red & 8'hF8, 8'h00} | {5'd0, green & 8'hFC, 3'd0} |
			{11'd0, blue[7:3]};
	end

	// Colour follows the mappers through the pipeline.
	for (genvar k = 2; k <= LAST; k++) begin : g_col
		always_ff @(posedge clk) begin
			col_s[k] <= col_s[k-1];
		end
	end

	nssr_bound_map u_cb (.clk, .s_in(cb_s1), .src_dim(src_w_q), .dst_dim(frm_w_q),
		.t_out(cb_t));
	nssr_bound_map u_ce (.clk, .s_in(ce_s1), .src_dim(src_w_q), .dst_dim(frm_w_q),
		.t_out(ce_t));
	nssr_bound_map u_rb (.clk, .s_in(rb_s1), .src_dim(src_h_q), .dst_dim(frm_h_q),
		.t_out(rb_t));
	nssr_bound_map u_re (.clk, .s_in(re_s1), .src_dim(src_h_q), .dst_dim(frm_h_q),
		.t_out(re_t));

	// Output stage: empty test, start offset and byte order.
	assign empty = (cb_t == ce_t) || (rb_t == re_t);
	assign pix   = 24'(rb_t * frm_w_q) + {11'd0, cb_t};

	always_ff @(posedge clk) begin
		col_begin    <= cb_t;
		col_end      <= ce_t;
		row_begin    <= rb_t;
		row_end      <= re_t;
		empty_span   <= empty;
		start_offset <= empty ? '0 : {pix, 1'b0};
		first_byte   <= hi_first_q ? col_s[LAST][15:8] : col_s[LAST][7:0];
		second_byte  <= hi_first_q ? col_s[LAST][7:0] : col_s[LAST][15:8];
	end

	// Every accepted rectangle gives one result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(LAST+1) done) else $error("result missing");

	// An empty span carries no offset.
	a_empty_off: assert property (@(posedge clk) disable iff (!arst_n)
		done && empty_span |-> start_offset == '0) else $error("offset on empty span");

	// A covered span is properly ordered.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && !empty_span |-> col_begin < col_end && row_begin < row_end)
		else $error("span out of order");

	// No boundary lands beyond the frame.
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> col_end <= frm_w_q && row_end <= frm_h_q) else $error("span beyond frame");

endmodule

// File: rtl/nssr_bound_map.sv
// ---------------------------------------------------------------------------
// nssr_bound_map
// Maps one source boundary s onto the target axis: the smallest t in [0,T]
// with (2t+1)*S >= 2*T*s, or T. Two arithmetic stages, a thirteen-stage
// restoring divider and a final select; one new boundary per cycle.
// ---------------------------------------------------------------------------
module nssr_bound_map
	import nssr_pkg::*;
(
	input  logic             clk,
	input  logic [POS_W-1:0] s_in,
	input  logic [DIM_W-1:0] src_dim,
	input  logic [DIM_W-1:0] dst_dim,
	output logic [DIM_W-1:0] t_out
);

	logic [27:0]      need_s1;
	logic [26:0]      lim_s1;
	logic [REM_W-1:0] rem_s  [0:DIM_W];
	logic [DIM_W-1:0] quo_s  [0:DIM_W];
	logic             zero_s [0:DIM_W];
	logic             over_s [0:DIM_W];
	logic [27:0]      diff;
	logic [DIM_W:0]   dsor;

	assign dsor = {src_dim, 1'b0};

	// First stage: 2*T*s and the clamp limit 2*S*T.
	always_ff @(posedge clk) begin
		need_s1 <= {27'(s_in * dst_dim), 1'b0};
		lim_s1  <= {26'(src_dim * dst_dim), 1'b0};
	end

	// Second stage: numerator for a rounded-up quotient, plus the two
	// special cases (result zero, result beyond T).
	assign diff = need_s1 - {15'd0, src_dim};

	always_ff @(posedge clk) begin
		zero_s[0] <= (need_s1 <= {15'd0, src_dim});
		over_s[0] <= (diff > {1'b0, lim_s1});
		rem_s[0]  <= {1'b0, diff} + {15'd0, dsor} - REM_W'(1);
		quo_s[0]  <= '0;
	end

	// Divider stages, one quotient bit each, most significant first.
	for (genvar j = 0; j < DIM_W; j++) begin : g_div
		localparam int K = DIM_W - 1 - j;
		logic [REM_W-1:0] trial;

		assign trial = {{(REM_W-DIM_W-1){1'b0}}, dsor} << K;

		always_ff @(posedge clk) begin
			zero_s[j+1] <= zero_s[j];
			over_s[j+1] <= over_s[j];
			if (rem_s[j] >= trial) begin
				rem_s[j+1] <= rem_s[j] - trial;
				quo_s[j+1] <= quo_s[j] | (DIM_W'(1) << K);
			end else begin
				rem_s[j+1] <= rem_s[j];
				quo_s[j+1] <= quo_s[j];
			end
		end
	end

	// Final select.
	always_ff @(posedge clk) begin
		if (zero_s[DIM_W]) begin
			t_out <= '0;
		end else if (over_s[DIM_W]) begin
			t_out <= dst_dim;
		end else begin
			t_out <= quo_s[DIM_W];
		end
	end

endmodule
